### src/four_ary_loser_tree_merge_top_macros.svh
// Assertion macros for the four-ary loser tree merge block.
// Used by the top level; expects clk and arst_n in scope at the point of use.
`ifndef FOUR_ARY_LOSER_TREE_MERGE_TOP_MACROS_SVH
`define FOUR_ARY_LOSER_TREE_MERGE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FLTM_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FLTM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fltm_pkg.sv
// Shared constants, types and elaboration helpers for the loser tree merge.
// No dependencies; used by the interfaces, the node store and the top level.
package fltm_pkg;

	localparam int DEF_MAX_STREAMS = 64;
	localparam int DEF_VALUE_BITS  = 31;
	localparam int FANOUT          = 4;

	localparam int               CFG_W        = 7;
	localparam logic [CFG_W-1:0] CFG_RESET    = 7'd64;
	localparam int               OUT_VALUE_W  = 31;
	localparam int               OUT_STREAM_W = 6;

	// Control of the node store for one cycle.
	typedef struct packed {
		logic rd_win;   // read the winner slot at rd_addr
		logic rd_lose;  // read final and pair loser slots at rd_addr
		logic wr_win;
		logic wr_fin;
		logic wr_p0;
		logic wr_p1;
	} store_ctl_t;

	// Number of tree levels needed for max_streams leaves.
	function automatic int levels_for(input int max_streams);
		int lv;
		int span;
		lv = 1;
		span = FANOUT;
		while (span < max_streams) begin
			span = span * FANOUT;
			lv++;
		end
		return lv;
	endfunction

	// Total tree nodes over all levels for max_streams leaves.
	function automatic int nodes_for(input int max_streams);
		int total;
		int cnt;
		total = 0;
		cnt = max_streams;
		do begin
			cnt = (cnt + FANOUT - 1) / FANOUT;
			total = total + cnt;
		end while (cnt > 1);
		return total;
	endfunction

endpackage

### src/fltm_ifs.sv
// Valid/ready channel interfaces for the loser tree merge block.
// Depends on fltm_pkg for default widths.
interface fltm_item_if #(
	parameter int VALUE_BITS = fltm_pkg::DEF_VALUE_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface fltm_result_if ();
	logic                              valid;
	logic                              ready;
	logic [fltm_pkg::OUT_VALUE_W-1:0]  winner_value;
	logic [fltm_pkg::OUT_STREAM_W-1:0] winner_stream;
	logic                              done_res;

	modport source (output valid, output winner_value, output winner_stream,
		output done_res, input ready);
	modport sink   (input valid, input winner_value, input winner_stream,
		input done_res, output ready);
endinterface

### src/fltm_node_store.sv
// Node store of the loser tree: one memory per slot (winner, final loser,
// two pair losers), one write address and one read address, registered reads.
module fltm_node_store #(
	parameter int NODES   = 21,
	parameter int NODE_W  = 5,
	parameter int ENTRY_W = 37
) (
	input  logic                 clk,
	input  fltm_pkg::store_ctl_t ctl,
	input  logic [NODE_W-1:0]    rd_addr,
	input  logic [NODE_W-1:0]    wr_addr,
	input  logic [ENTRY_W-1:0]   wr_win,
	input  logic [ENTRY_W-1:0]   wr_fin,
	input  logic [ENTRY_W-1:0]   wr_p0,
	input  logic [ENTRY_W-1:0]   wr_p1,
	output logic [ENTRY_W-1:0]   rd_win,
	output logic [ENTRY_W-1:0]   rd_fin,
	output logic [ENTRY_W-1:0]   rd_p0,
	output logic [ENTRY_W-1:0]   rd_p1
);

	logic [ENTRY_W-1:0] mem_win [NODES];
	logic [ENTRY_W-1:0] mem_fin [NODES];
	logic [ENTRY_W-1:0] mem_p0  [NODES];
	logic [ENTRY_W-1:0] mem_p1  [NODES];

	always_ff @(posedge clk) begin
		if (ctl.wr_win) mem_win[wr_addr] <= wr_win;
		if (ctl.wr_fin) mem_fin[wr_addr] <= wr_fin;
		if (ctl.wr_p0)  mem_p0[wr_addr]  <= wr_p0;
		if (ctl.wr_p1)  mem_p1[wr_addr]  <= wr_p1;
	end

	// Hold read data until the next read of the same group.
	always_ff @(posedge clk) begin
		if (ctl.rd_win) rd_win <= mem_win[rd_addr];
		if (ctl.rd_lose) begin
			rd_fin <= mem_fin[rd_addr];
			rd_p0  <= mem_p0[rd_addr];
			rd_p1  <= mem_p1[rd_addr];
		end
	end

endmodule

### src/four_ary_loser_tree_merge_top.sv
// Top level of the four-ary loser tree merge.
// Depends on fltm_pkg, fltm_ifs.sv, fltm_node_store and the assertion macro header.
//
// Merges up to MAX_STREAMS descending, zero-terminated streams. Send the stream
// heads as load requests (kind 0) in stream order; when num_streams heads are in,
// the block builds a 4-ary loser tree and posts the largest head with its stream
// index. Each refill request (kind 1) carries the next value of the stream just
// posted; the block replays it up the tree and posts the new winner. done_res marks
// a winner of 0, after which refills are dropped until a load starts a new run.
// A load that completes no run leaves the block ready for the next request. The last
// load of a run builds the tree and keeps the block busy: the layout of the level
// counts and then of the start offsets, then per tree node the reads of the four
// candidates from the head or node memory and three plays, then the posting.
// A refill keeps it busy too: a read of the node losers, then per level one play
// against the pair loser and one against the node loser, then the posting, each play
// on the single shared comparator, each depending on the last. The request channel
// is not ready while a build or replay runs. A posted result sits in an output
// register, so loads keep flowing while it waits; the block stalls only when a new
// result is due and the old one is still held.
// num_streams may be written only while idle; a run keeps the count latched at build.
module four_ary_loser_tree_merge_top #(
	parameter int MAX_STREAMS = fltm_pkg::DEF_MAX_STREAMS,
	parameter int VALUE_BITS  = fltm_pkg::DEF_VALUE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [fltm_pkg::CFG_W-1:0] cfg_wr_data,
	fltm_item_if.sink                  items,
	fltm_result_if.source              results
);

`include "four_ary_loser_tree_merge_top_macros.svh"

	localparam int LEAF_W  = $clog2(MAX_STREAMS);
	localparam int CNT_W   = $clog2(MAX_STREAMS + 1);
	localparam int IDX_W   = CNT_W + 1;
	localparam int NLV     = fltm_pkg::levels_for(MAX_STREAMS);
	localparam int NODES   = fltm_pkg::nodes_for(MAX_STREAMS);
	localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int NCNT_W  = $clog2(NODES + 1);
	localparam int POS_W   = NCNT_W + 1;
	localparam int LVL_W   = (NLV > 1) ? $clog2(NLV) : 1;
	localparam int ENTRY_W = VALUE_BITS + LEAF_W;
	localparam int CMP_W   = (CNT_W > fltm_pkg::CFG_W) ? CNT_W : fltm_pkg::CFG_W;

	typedef struct packed {
		logic [VALUE_BITS-1:0] score;
		logic [LEAF_W-1:0]     leaf;
	} entry_t;

	typedef enum logic [1:0] {
		PH_LOADING,
		PH_MERGING,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAY_CNT,
		S_LAY_START,
		S_B_RD,
		S_B_P01,
		S_B_P23,
		S_B_FIN,
		S_R_RD,
		S_R_D1,
		S_R_D2,
		S_EMIT
	} state_t;

	// Control state
	state_t                     state_q;
	phase_t                     phase_q;
	logic [fltm_pkg::CFG_W-1:0] num_streams_q;
	logic [CNT_W-1:0]           heads_loaded_q;
	logic [CNT_W-1:0]           run_n_q;
	entry_t                     cw_q;
	logic [NCNT_W-1:0]          lvl_cnt_q   [NLV];
	logic [NCNT_W-1:0]          lvl_start_q [NLV];
	logic [LVL_W-1:0]           top_q;
	logic [LVL_W-1:0]           lvl_q;
	logic [NCNT_W-1:0]          node_i_q;
	logic [2:0]                 j_q;
	logic                       out_valid_q;

	// Datapath registers
	logic                                 pend_pad_q;
	logic [LEAF_W-1:0]                    pend_leaf_q;
	entry_t                               cand_q [4];
	entry_t                               w01_q;
	entry_t                               l01_q;
	entry_t                               w23_q;
	entry_t                               l23_q;
	entry_t                               climb_q;
	entry_t                               fin_hold_q;
	logic [POS_W-1:0]                     pos_q;
	logic                                 pair_q;
	logic [VALUE_BITS-1:0]                head_rd_q;
	logic [fltm_pkg::OUT_VALUE_W-1:0]     out_value_q;
	logic [fltm_pkg::OUT_STREAM_W-1:0]    out_stream_q;
	logic                                 out_done_q;
	logic [VALUE_BITS-1:0]                head_mem [MAX_STREAMS];

	// Combinational signals
	logic                 item_acc;
	logic                 out_free;
	logic [CMP_W-1:0]     ns_ext;
	logic [CNT_W-1:0]     n_eff_c;
	logic                 restart_c;
	logic [CNT_W-1:0]     base_c;
	logic [CNT_W-1:0]     next_cnt_c;
	logic [CNT_W:0]       n_plus3;
	logic [NCNT_W:0]      cnt_plus3 [NLV];
	logic [NCNT_W-1:0]    cnt_c   [NLV];
	logic [NCNT_W-1:0]    start_c [NLV];
	logic [LVL_W-1:0]     top_c;
	logic [LVL_W-1:0]     lvl_pm1;
	logic [IDX_W-1:0]     idx_c;
	logic                 cand_ok_c;
	entry_t               cand_in_c;
	logic                 head_rd_en;
	logic [LEAF_W-1:0]    leaf_in_c;
	logic [NCNT_W-1:0]    rep_node_c;
	logic [NCNT_W-1:0]    next_node_c;
	entry_t               cmp_a;
	entry_t               cmp_b;
	logic                 gt_c;
	entry_t               win_c;
	entry_t               lose_c;

	fltm_pkg::store_ctl_t st_ctl;
	logic [NODE_W-1:0]    st_rd_addr;
	logic [NODE_W-1:0]    st_wr_addr;
	entry_t               st_wr_win;
	entry_t               st_wr_fin;
	entry_t               st_wr_p0;
	entry_t               st_wr_p1;
	entry_t               st_rd_win;
	entry_t               st_rd_fin;
	entry_t               st_rd_p0;
	entry_t               st_rd_p1;

	assign items.ready           = (state_q == S_IDLE);
	assign item_acc              = items.valid && items.ready;
	assign out_free              = !out_valid_q || results.ready;
	assign results.valid         = out_valid_q;
	assign results.winner_value  = out_value_q;
	assign results.winner_stream = out_stream_q;
	assign results.done_res      = out_done_q;

	// Effective stream count: zero counts as one, clamp to MAX_STREAMS.
	assign ns_ext  = CMP_W'(num_streams_q);
	assign n_eff_c = (ns_ext == '0) ? CNT_W'(1) :
		(ns_ext > CMP_W'(MAX_STREAMS)) ? CNT_W'(MAX_STREAMS) : CNT_W'(ns_ext);

	// A load starts a new run after a merge, or when the count was lowered mid-load.
	assign restart_c  = (phase_q != PH_LOADING) || (heads_loaded_q >= n_eff_c);
	assign base_c     = restart_c ? '0 : heads_loaded_q;
	assign next_cnt_c = base_c + CNT_W'(1);

	// Refill leaf: fall back to stream 0 if the last winner lies outside the run.
	assign leaf_in_c = (CNT_W'(cw_q.leaf) >= run_n_q) ? '0 : cw_q.leaf;

	// Level node counts: ceil(n/4) and so on upward.
	always_comb begin
		n_plus3 = {1'b0, run_n_q} + (CNT_W+1)'(3);
		cnt_c[0] = NCNT_W'(n_plus3 >> 2);
		cnt_plus3[0] = {1'b0, cnt_c[0]} + (NCNT_W+1)'(3);
		for (int k = 1; k < NLV; k++) begin
			cnt_c[k] = NCNT_W'(cnt_plus3[k-1] >> 2);
			cnt_plus3[k] = {1'b0, cnt_c[k]} + (NCNT_W+1)'(3);
		end
	end

	// Level start offsets: root level at 0, lower levels after the ones above.
	// A level above the top has a parent level of one node and adds nothing.
	always_comb begin
		start_c[NLV-1] = '0;
		for (int k = NLV - 2; k >= 0; k--) begin
			start_c[k] = start_c[k+1] +
				((lvl_cnt_q[k] > NCNT_W'(1)) ? lvl_cnt_q[k+1] : '0);
		end
		top_c = '0;
		for (int k = 0; k < NLV; k++) begin
			if (lvl_cnt_q[k] > NCNT_W'(1)) top_c = top_c + LVL_W'(1);
		end
	end

	// Build candidate fetch: index j of the current node, padded past the level end.
	assign lvl_pm1 = lvl_q - LVL_W'(1);
	assign idx_c   = IDX_W'({node_i_q, 2'b00}) + IDX_W'(j_q[1:0]);

	always_comb begin
		if (lvl_q == '0) begin
			cand_ok_c = idx_c < IDX_W'(run_n_q);
		end else begin
			cand_ok_c = idx_c < IDX_W'(lvl_cnt_q[lvl_pm1]);
		end
		if (pend_pad_q) begin
			cand_in_c = '0;
		end else if (lvl_q == '0) begin
			cand_in_c = '{score: head_rd_q, leaf: pend_leaf_q};
		end else begin
			cand_in_c = st_rd_win;
		end
	end

	assign head_rd_en = (state_q == S_B_RD) && (j_q != 3'd4) && (lvl_q == '0) && cand_ok_c;

	// Replay node addresses for this level and the next one up.
	assign rep_node_c  = lvl_start_q[lvl_q] + NCNT_W'(pos_q);
	assign next_node_c = lvl_start_q[lvl_q + LVL_W'(1)] + NCNT_W'(pos_q >> 2);

	// Shared comparator: a wins only if strictly larger, so ties go to b.
	// Build plays put the right operand on b; replay duels put the climber on b.
	always_comb begin
		case (state_q)
			S_B_P01: begin
				cmp_a = cand_q[0];
				cmp_b = cand_q[1];
			end
			S_B_P23: begin
				cmp_a = cand_q[2];
				cmp_b = cand_q[3];
			end
			S_B_FIN: begin
				cmp_a = w01_q;
				cmp_b = w23_q;
			end
			S_R_D1: begin
				cmp_a = pair_q ? st_rd_p1 : st_rd_p0;
				cmp_b = climb_q;
			end
			S_R_D2: begin
				cmp_a = fin_hold_q;
				cmp_b = climb_q;
			end
			default: begin
				cmp_a = climb_q;
				cmp_b = climb_q;
			end
		endcase
		gt_c   = cmp_a.score > cmp_b.score;
		win_c  = gt_c ? cmp_a : cmp_b;
		lose_c = gt_c ? cmp_b : cmp_a;
	end

	// Node store requests
	always_comb begin
		st_ctl     = '0;
		st_rd_addr = '0;
		st_wr_addr = NODE_W'(rep_node_c);
		st_wr_win  = win_c;
		st_wr_fin  = lose_c;
		st_wr_p0   = lose_c;
		st_wr_p1   = lose_c;
		case (state_q)
			S_B_RD: begin
				st_ctl.rd_win = (j_q != 3'd4) && (lvl_q != '0) && cand_ok_c;
				st_rd_addr    = NODE_W'(lvl_start_q[lvl_pm1] + NCNT_W'(idx_c));
			end
			S_B_FIN: begin
				st_ctl.wr_win = 1'b1;
				st_ctl.wr_fin = 1'b1;
				st_ctl.wr_p0  = 1'b1;
				st_ctl.wr_p1  = 1'b1;
				st_wr_addr    = NODE_W'(lvl_start_q[lvl_q] + node_i_q);
				st_wr_p0      = l01_q;
				st_wr_p1      = l23_q;
			end
			S_R_RD: begin
				st_ctl.rd_lose = 1'b1;
				st_rd_addr     = NODE_W'(rep_node_c);
			end
			S_R_D1: begin
				// Write back the pair loser; prefetch the next level's losers.
				st_ctl.wr_p0   = !pair_q;
				st_ctl.wr_p1   = pair_q;
				st_ctl.rd_lose = (lvl_q != top_q);
				st_rd_addr     = NODE_W'(next_node_c);
			end
			S_R_D2: begin
				st_ctl.wr_fin = 1'b1;
			end
			default: begin
				st_ctl = '0;
			end
		endcase
	end

	fltm_node_store #(
		.NODES   (NODES),
		.NODE_W  (NODE_W),
		.ENTRY_W (ENTRY_W)
	) u_store (
		.clk     (clk),
		.ctl     (st_ctl),
		.rd_addr (st_rd_addr),
		.wr_addr (st_wr_addr),
		.wr_win  (st_wr_win),
		.wr_fin  (st_wr_fin),
		.wr_p0   (st_wr_p0),
		.wr_p1   (st_wr_p1),
		.rd_win  (st_rd_win),
		.rd_fin  (st_rd_fin),
		.rd_p0   (st_rd_p0),
		.rd_p1   (st_rd_p1)
	);

	// Stream head memory: written by loads, read during the leaf level build.
	always_ff @(posedge clk) begin
		if (item_acc && !items.kind) head_mem[base_c[LEAF_W-1:0]] <= items.value;
		if (head_rd_en) head_rd_q <= head_mem[idx_c[LEAF_W-1:0]];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			phase_q        <= PH_LOADING;
			num_streams_q  <= fltm_pkg::CFG_RESET;
			heads_loaded_q <= '0;
			run_n_q        <= CNT_W'(1);
			cw_q           <= '0;
			lvl_cnt_q      <= '{default: '0};
			lvl_start_q    <= '{default: '0};
			top_q          <= '0;
			lvl_q          <= '0;
			node_i_q       <= '0;
			j_q            <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) num_streams_q <= cfg_wr_data;
			// Drop a taken result; an emit in this cycle reloads the register instead.
			if (out_valid_q && results.ready && (state_q != S_EMIT)) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (!items.kind) begin
							phase_q        <= PH_LOADING;
							heads_loaded_q <= next_cnt_c;
							if (next_cnt_c == n_eff_c) begin
								run_n_q <= n_eff_c;
								state_q <= S_LAY_CNT;
							end
						end else if (phase_q == PH_MERGING) begin
							// Advance the refill from the last winner's leaf.
							climb_q <= '{score: items.value, leaf: leaf_in_c};
							pos_q   <= POS_W'(leaf_in_c >> 2);
							pair_q  <= leaf_in_c[1];
							lvl_q   <= '0;
							state_q <= S_R_RD;
						end
					end
				end
				S_LAY_CNT: begin
					lvl_cnt_q <= cnt_c;
					state_q   <= S_LAY_START;
				end
				S_LAY_START: begin
					lvl_start_q <= start_c;
					top_q       <= top_c;
					lvl_q       <= '0;
					node_i_q    <= '0;
					j_q         <= '0;
					state_q     <= S_B_RD;
				end
				S_B_RD: begin
					if (j_q != 3'd4) begin
						pend_pad_q  <= !cand_ok_c;
						pend_leaf_q <= idx_c[LEAF_W-1:0];
					end
					if (j_q != 3'd0) cand_q[2'(j_q - 3'd1)] <= cand_in_c;
					if (j_q == 3'd4) begin
						j_q     <= '0;
						state_q <= S_B_P01;
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				S_B_P01: begin
					w01_q   <= win_c;
					l01_q   <= lose_c;
					state_q <= S_B_P23;
				end
				S_B_P23: begin
					w23_q   <= win_c;
					l23_q   <= lose_c;
					state_q <= S_B_FIN;
				end
				S_B_FIN: begin
					if (node_i_q == lvl_cnt_q[lvl_q] - NCNT_W'(1)) begin
						node_i_q <= '0;
						if (lvl_q == top_q) begin
							cw_q    <= win_c;
							state_q <= S_EMIT;
						end else begin
							lvl_q   <= lvl_q + LVL_W'(1);
							state_q <= S_B_RD;
						end
					end else begin
						node_i_q <= node_i_q + NCNT_W'(1);
						state_q  <= S_B_RD;
					end
				end
				S_R_RD: begin
					state_q <= S_R_D1;
				end
				S_R_D1: begin
					climb_q    <= win_c;
					fin_hold_q <= st_rd_fin;
					state_q    <= S_R_D2;
				end
				S_R_D2: begin
					climb_q <= win_c;
					if (lvl_q == top_q) begin
						cw_q    <= win_c;
						state_q <= S_EMIT;
					end else begin
						lvl_q   <= lvl_q + LVL_W'(1);
						pos_q   <= pos_q >> 2;
						pair_q  <= pos_q[1];
						state_q <= S_R_D1;
					end
				end
				S_EMIT: begin
					// Hold the result until the output register frees up.
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= fltm_pkg::OUT_VALUE_W'(cw_q.score);
						out_stream_q <= fltm_pkg::OUT_STREAM_W'(cw_q.leaf);
						out_done_q   <= (cw_q.score == '0);
						phase_q      <= (cw_q.score == '0) ? PH_DONE : PH_MERGING;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A refill outside a merge must be dropped without starting any work.
	`FLTM_ASSERT_NEXT(a_refill_dropped, item_acc && items.kind && (phase_q != PH_MERGING), state_q == S_IDLE, "refill outside merge started work")

	// Posting a result always leaves the run in merging or done.
	`FLTM_ASSERT_NEXT(a_emit_posts, (state_q == S_EMIT) && out_free, results.valid && (phase_q != PH_LOADING), "emit did not post a result")

	// The replay walk stays inside the node store.
	`FLTM_ASSERT_SAME(a_replay_node, (state_q == S_R_D1) || (state_q == S_R_D2), rep_node_c < NCNT_W'(NODES), "replay node out of range")

	// Build and replay only run on a fully loaded run.
	`FLTM_ASSERT_SAME(a_run_loaded, (state_q != S_IDLE) && (state_q != S_EMIT), heads_loaded_q == run_n_q, "work started on a partial load")

endmodule
